// ===== design/atwl_pkg.sv =====
// Package for the array trie word lookup block.
// Holds the request, result and branch entry types, codes and sizing constants.
// No dependencies; every design file but atwl_ram refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package atwl_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 4096;
   localparam int IDX_W               = 12;
   localparam int LETTER_W            = 8;

   typedef enum logic {
      CMD_WRITE  = 1'b0,
      CMD_LETTER = 1'b1
   } cmd_type;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   typedef struct packed {
      cmd_type             cmd;
      logic [IDX_W-1:0]    entry_index;
      logic [LETTER_W-1:0] entry_letter;
      logic                entry_last_sibling;
      logic [IDX_W-1:0]    entry_child;
      logic                entry_terminal;
      logic [LETTER_W-1:0] word_letter;
      logic                word_end;
   } req_type;

   typedef struct packed {
      logic             word_found;
      logic [IDX_W-1:0] match_index;
   } rsp_type;

   typedef struct packed {
      logic                terminal;
      logic [IDX_W-1:0]    child;
      logic                last_sibling;
      logic [LETTER_W-1:0] letter;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Commands from the sequencer to the scan unit.
   typedef struct packed {
      logic load;
      logic step;
   } scan_ctrl_type;

   // Status from the scan unit back to the sequencer.
   typedef struct packed {
      logic             start_ok;
      logic             hit;
      logic             stop;
      logic [IDX_W-1:0] hit_index;
   } scan_stat_type;

endpackage

`default_nettype wire

// ===== design/array_trie_word_lookup.sv =====
// A write request lands in the table as it is accepted. A letter request that scans
// loads the scan unit, which reads one sibling entry per cycle until the scan ends.
// Busy stays high while it runs; the next request may follow at once. A word's result
// shows for one cycle, in the cycle after its final letter's scan ends or is skipped.
// The receiver cannot stall. Synchronous active-high reset clears the sequencer, the
// cursor and the failed flag; the table contents are undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module array_trie_word_lookup #(
   parameter int TABLE_DEPTH = atwl_pkg::TABLE_DEPTH_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output      logic              busy,
   input  wire atwl_pkg::req_type req_item,
   output      logic              rsp_strobe,
   output      atwl_pkg::rsp_type rsp_item
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = ((AW > atwl_pkg::IDX_W) ? AW : atwl_pkg::IDX_W) + 1;

   // Sequencer state, the cursor that marks the sibling group for the next
   // letter, the failed flag of the current word and the result register.
   atwl_pkg::state_type          state_ff, state_in;
   logic [atwl_pkg::IDX_W-1:0]   cursor_ff, cursor_in;
   logic                         failed_ff, failed_in;
   logic                         word_end_ff, word_end_in;
   logic                         rsp_strobe_ff, rsp_strobe_in;
   atwl_pkg::rsp_type            rsp_item_ff, rsp_item_in;

   logic                         accept;
   logic                         wr_en;
   logic [AW-1:0]                rd_addr;
   logic [atwl_pkg::ENTRY_W-1:0] rd_data;
   atwl_pkg::entry_type          entry;
   atwl_pkg::entry_type          wr_entry;
   atwl_pkg::scan_ctrl_type      scan_ctrl;
   atwl_pkg::scan_stat_type      scan_stat;

   assign accept = start && (state_ff == atwl_pkg::ST_IDLE);
   assign entry  = atwl_pkg::entry_type'(rd_data);

   // Writes go straight into the table; an index beyond the table is dropped.
   assign wr_en = accept && (req_item.cmd == atwl_pkg::CMD_WRITE) &&
                  (CW'(req_item.entry_index) < CW'(TABLE_DEPTH));

   assign wr_entry.terminal     = req_item.entry_terminal;
   assign wr_entry.child        = req_item.entry_child;
   assign wr_entry.last_sibling = req_item.entry_last_sibling;
   assign wr_entry.letter       = req_item.entry_letter;

   atwl_ram #(
      .WIDTH (atwl_pkg::ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(req_item.entry_index)),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   atwl_scan #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_scan (
      .clock        (clock),
      .ctrl         (scan_ctrl),
      .start_index  (cursor_ff),
      .start_letter (req_item.word_letter),
      .rd_data      (rd_data),
      .rd_addr      (rd_addr),
      .stat         (scan_stat)
   );

   // Next state. A letter of a word that already failed, or whose sibling
   // group would start beyond the table, does not scan at all. Otherwise the
   // scan unit walks the sibling group, one entry per cycle, until the letter
   // matches or the entry carries the last-sibling mark or the table ends.
   // The final letter of a word loads the result register and rearms the
   // cursor and the failed flag for the next word.
   always_comb begin
      state_in      = state_ff;
      cursor_in     = cursor_ff;
      failed_in     = failed_ff;
      word_end_in   = word_end_ff;
      rsp_strobe_in = 1'b0;
      rsp_item_in   = rsp_item_ff;
      scan_ctrl     = '0;

      unique case (state_ff)
         atwl_pkg::ST_IDLE: begin
            if (accept && (req_item.cmd == atwl_pkg::CMD_LETTER)) begin
               if (failed_ff || !scan_stat.start_ok) begin
                  if (req_item.word_end) begin
                     rsp_strobe_in = 1'b1;
                     rsp_item_in   = '0;
                     cursor_in     = '0;
                     failed_in     = 1'b0;
                  end else begin
                     failed_in = 1'b1;
                  end
               end else begin
                  scan_ctrl.load = 1'b1;
                  word_end_in    = req_item.word_end;
                  state_in       = atwl_pkg::ST_SCAN;
               end
            end
         end
         atwl_pkg::ST_SCAN: begin
            if (scan_stat.hit) begin
               state_in = atwl_pkg::ST_IDLE;
               if (word_end_ff) begin
                  rsp_strobe_in           = 1'b1;
                  rsp_item_in.word_found  = entry.terminal;
                  rsp_item_in.match_index = scan_stat.hit_index;
                  cursor_in               = '0;
                  failed_in               = 1'b0;
               end else if (entry.child == '0) begin
                  // The word runs on past a leaf: it cannot be in the trie.
                  failed_in = 1'b1;
               end else begin
                  cursor_in = entry.child;
               end
            end else if (scan_stat.stop) begin
               state_in = atwl_pkg::ST_IDLE;
               if (word_end_ff) begin
                  rsp_strobe_in = 1'b1;
                  rsp_item_in   = '0;
                  cursor_in     = '0;
                  failed_in     = 1'b0;
               end else begin
                  failed_in = 1'b1;
               end
            end else begin
               scan_ctrl.step = 1'b1;
            end
         end
         default: begin
            state_in = atwl_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= atwl_pkg::ST_IDLE;
         cursor_ff     <= '0;
         failed_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cursor_ff     <= cursor_in;
         failed_ff     <= failed_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      word_end_ff <= word_end_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign busy       = (state_ff != atwl_pkg::ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

endmodule

`default_nettype wire

// ===== design/atwl_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Parameterized in width and depth; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module atwl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/atwl_scan.sv =====
// Sibling scan unit: scan index register, incrementer, letter compare and
// table end check. Depends on atwl_pkg for the entry and control types.
`timescale 1ns / 1ps
`default_nettype none

module atwl_scan #(
   parameter int TABLE_DEPTH = atwl_pkg::TABLE_DEPTH_DEFAULT
) (
   input  wire logic                             clock,
   input  wire atwl_pkg::scan_ctrl_type          ctrl,
   input  wire logic [atwl_pkg::IDX_W-1:0]       start_index,
   input  wire logic [atwl_pkg::LETTER_W-1:0]    start_letter,
   input  wire logic [atwl_pkg::ENTRY_W-1:0]     rd_data,
   output      logic [$clog2(TABLE_DEPTH)-1:0]   rd_addr,
   output      atwl_pkg::scan_stat_type          stat
);

   localparam int AW   = $clog2(TABLE_DEPTH);
   // Wide enough for any start index and for the table depth itself.
   localparam int CW   = ((AW > atwl_pkg::IDX_W) ? AW : atwl_pkg::IDX_W) + 1;

   logic [CW-1:0]                 idx_ff, idx_in, next_idx;
   logic [atwl_pkg::LETTER_W-1:0] letter_ff, letter_in;
   atwl_pkg::entry_type           entry;

   assign entry    = atwl_pkg::entry_type'(rd_data);
   assign next_idx = idx_ff + CW'(1);

   // The read for the following entry is issued while the current one is checked.
   assign rd_addr = ctrl.load ? AW'(start_index) : next_idx[AW-1:0];

   assign stat.start_ok  = CW'(start_index) < CW'(TABLE_DEPTH);
   assign stat.hit       = entry.letter == letter_ff;
   assign stat.stop      = entry.last_sibling || (next_idx >= CW'(TABLE_DEPTH));
   assign stat.hit_index = idx_ff[atwl_pkg::IDX_W-1:0];

   always_comb begin
      idx_in    = idx_ff;
      letter_in = letter_ff;
      if (ctrl.load) begin
         idx_in    = CW'(start_index);
         letter_in = start_letter;
      end else if (ctrl.step) begin
         idx_in = next_idx;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      letter_ff <= letter_in;
   end

endmodule

`default_nettype wire

// ===== design/atwl_checker.sv =====
// Port-level checker for the array trie word lookup block, with its bind.
// Depends on atwl_pkg for the request and result types.
`timescale 1ns / 1ps
`default_nettype none

module atwl_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              start,
   input wire logic              busy,
   input wire atwl_pkg::req_type req_item,
   input wire logic              rsp_strobe,
   input wire atwl_pkg::rsp_type rsp_item
);

   logic accept;
   assign accept = start && !busy;

   // Two results never show in consecutive cycles.
   a_no_back_to_back : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("two results in consecutive cycles");

   // The result register is loaded as the scan ends or while idle, so it shows while idle.
   a_rsp_while_idle : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result shown while the block is busy");

   a_result_has_cause : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(busy) || $past(accept &&
         (req_item.cmd == atwl_pkg::CMD_LETTER) && req_item.word_end)))
      else $error("result without a final letter or a scan");

   a_write_no_result : assert property (@(posedge clock) disable iff (reset)
      (accept && (req_item.cmd == atwl_pkg::CMD_WRITE)) |=> !rsp_strobe)
      else $error("write request produced a result");

   a_mid_letter_no_result : assert property (@(posedge clock) disable iff (reset)
      (accept && (req_item.cmd == atwl_pkg::CMD_LETTER) && !req_item.word_end)
      |=> !rsp_strobe)
      else $error("result right after a non-final letter");

endmodule

bind array_trie_word_lookup atwl_checker u_atwl_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_item   (req_item),
   .rsp_strobe (rsp_strobe),
   .rsp_item   (rsp_item)
);

`default_nettype wire

// ===== sim/array_trie_word_lookup_tb.sv =====
// Self-checking testbench for the array trie word lookup block.
// Loads the branch table, runs directed and random word lookups, and checks every result.
// Depends on atwl_pkg and array_trie_word_lookup.
`timescale 1ns / 1ps

module array_trie_word_lookup_tb;

   localparam int DEPTH        = atwl_pkg::TABLE_DEPTH_DEFAULT;
   localparam int REQ_W        = $bits(atwl_pkg::req_type);
   localparam int REGION       = 128;
   localparam int RANDOM_ITEMS = 850;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   atwl_pkg::req_type req_item;
   logic              rsp_strobe;
   atwl_pkg::rsp_type rsp_item;

   // Our own copy of the lookup state: the branch table, the position of the
   // sibling group that the next letter scans, and whether the word in flight
   // has already failed.
   atwl_pkg::entry_type branch_mem [DEPTH];
   logic [11:0]         walk_cursor = '0;
   bit                  word_dead   = 1'b0;

   // Results that accepted requests have earned but the block has not yet shown.
   atwl_pkg::rsp_type expected_results [$];

   int sent_count  = 0;
   int error_count = 0;
   bit gaps_on     = 1'b1;

   array_trie_word_lookup i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Scans the sibling group that begins at start_idx for a letter. The scan stops
   // at the first matching entry, at an entry carrying the last-sibling mark, or at
   // the end of the table, in which case the letter is not found.
   function automatic bit find_branch(input int start_idx, input logic [7:0] letter,
                                      output int hit);
      int idx;
      hit = 0;
      for (idx = start_idx; idx < DEPTH; idx++) begin
         if (branch_mem[idx].letter == letter) begin
            hit = idx;
            return 1'b1;
         end
         if (branch_mem[idx].last_sibling)
            return 1'b0;
      end
      return 1'b0;
   endfunction

   // Advances the lookup state by one accepted request and reports the result
   // that the request earns, if any. Only a word's final letter earns one.
   function automatic void apply_request(input atwl_pkg::req_type r, output bit has_rsp,
                                         output atwl_pkg::rsp_type want);
      atwl_pkg::entry_type e;
      int                  hit;
      has_rsp = 1'b0;
      want    = '0;
      e       = '0;
      hit     = 0;
      if (r.cmd == atwl_pkg::CMD_WRITE) begin
         // A write lands even in the middle of a word; the cursor stays put.
         if (r.entry_index < DEPTH) begin
            e.letter       = r.entry_letter;
            e.last_sibling = r.entry_last_sibling;
            e.child        = r.entry_child;
            e.terminal     = r.entry_terminal;
            branch_mem[r.entry_index] = e;
         end
         return;
      end
      // A failed word skips the scan for all its remaining letters.
      if (!word_dead) begin
         if (find_branch(walk_cursor, r.word_letter, hit)) begin
            e = branch_mem[hit];
            if (!r.word_end) begin
               // Running on past a leaf fails the word rather than restarting at the root.
               if (e.child == '0)
                  word_dead = 1'b1;
               else
                  walk_cursor = e.child;
            end
         end else begin
            word_dead = 1'b1;
         end
      end
      if (r.word_end) begin
         has_rsp = 1'b1;
         if (!word_dead) begin
            want.word_found  = e.terminal;
            want.match_index = hit[atwl_pkg::IDX_W-1:0];
         end
         walk_cursor = '0;
         word_dead   = 1'b0;
      end
   endfunction

   function automatic atwl_pkg::req_type random_request();
      logic [63:0] bits64;
      bits64 = {$urandom, $urandom};
      return atwl_pkg::req_type'(bits64[REQ_W-1:0]);
   endfunction

   // A write to a random place in the loaded region with random content. Child
   // indexes stay inside the region, and the region's last entry always keeps
   // the last-sibling mark. Last-sibling marks are kept fairly rare elsewhere so
   // that sibling groups span a few entries.
   function automatic atwl_pkg::req_type random_write();
      atwl_pkg::req_type r;
      r = random_request();
      r.cmd                = atwl_pkg::CMD_WRITE;
      r.entry_index        = 12'($urandom_range(REGION - 1));
      r.entry_last_sibling = ($urandom_range(3) == 0);
      r.entry_child        = 12'($urandom_range(REGION - 1));
      if ($urandom_range(7) == 0)
         r.entry_child = '0;
      if (r.entry_index == 12'(REGION - 1))
         r.entry_last_sibling = 1'b1;
      return r;
   endfunction

   function automatic atwl_pkg::req_type make_write(input logic [11:0] idx,
                                                    input logic [7:0] letter,
                                                    input logic last,
                                                    input logic [11:0] child,
                                                    input logic term);
      atwl_pkg::req_type r;
      r = random_request();
      r.cmd                = atwl_pkg::CMD_WRITE;
      r.entry_index        = idx;
      r.entry_letter       = letter;
      r.entry_last_sibling = last;
      r.entry_child        = child;
      r.entry_terminal     = term;
      return r;
   endfunction

   function automatic atwl_pkg::req_type make_letter(input logic [7:0] letter,
                                                     input logic word_end);
      atwl_pkg::req_type r;
      r = random_request();
      r.cmd         = atwl_pkg::CMD_LETTER;
      r.word_letter = letter;
      r.word_end    = word_end;
      return r;
   endfunction

   // Picks a letter that the next scan will usually find: a random entry of the
   // sibling group at the cursor. Now and then a random byte, which usually misses.
   function automatic logic [7:0] pick_branch_letter();
      int n;
      int idx;
      if (word_dead || $urandom_range(9) == 0)
         return 8'($urandom_range(255));
      n   = 1;
      idx = walk_cursor;
      while (!branch_mem[idx].last_sibling && idx + 1 < DEPTH && n < 32) begin
         idx++;
         n++;
      end
      return branch_mem[walk_cursor + $urandom_range(n - 1)].letter;
   endfunction

   // Sends one request. With gaps enabled, start drops now and then while junk sits
   // on the request bus. The request is accepted at the
   // first rising edge where busy is low; the prediction is made right there.
   task automatic send_request(input atwl_pkg::req_type r);
      bit                has_rsp;
      atwl_pkg::rsp_type want;
      while (gaps_on && $urandom_range(99) < 12) begin
         start    <= 1'b0;
         req_item <= random_request();
         @(posedge clock);
      end
      req_item <= r;
      start    <= 1'b1;
      do
         @(posedge clock);
      while (busy !== 1'b0);
      apply_request(r, has_rsp, want);
      if (has_rsp)
         expected_results = {expected_results, want};
      sent_count++;
   endtask

   task automatic send_spelled(input string s);
      int k;
      for (k = 0; k < s.len(); k++)
         send_request(make_letter(s[k], k == s.len() - 1));
   endtask

   // One word of up to len letters. Well-formed words follow the branches that
   // the table holds; noisy words are random bytes. A word may stop early on a
   // leaf, and a write may slip in between its letters.
   task automatic send_word(input int len, input bit noisy);
      int          k;
      int          hit;
      bit          last;
      logic [7:0]  letter;
      for (k = 0; k < len; k++) begin
         last = (k == len - 1);
         if ($urandom_range(19) == 0)
            send_request(random_write());
         letter = noisy ? 8'($urandom_range(255)) : pick_branch_letter();
         if (!last && !word_dead) begin
            if (find_branch(walk_cursor, letter, hit)) begin
               if (branch_mem[hit].child == '0 && $urandom_range(4) != 0)
                  last = 1'b1;
            end
         end
         send_request(make_letter(letter, last));
         if (last)
            break;
      end
   endtask

   // The low region of the table is written before any lookup. Every random child index
   // points into that region and its last entry carries the last-sibling mark, so
   // no scan ever reads an entry that holds no defined content. The directed trie
   // adds the very last table entry, which is reached only through its own branch.
   task automatic test_table_load();
      int                i;
      atwl_pkg::req_type r;
      for (i = 0; i < REGION; i++) begin
         r = random_write();
         r.entry_index = i[11:0];
         if (i == REGION - 1)
            r.entry_last_sibling = 1'b1;
         send_request(r);
      end
   endtask

   // A small hand-built trie at the root: "cat", "c" -> "a" non-terminal, a leaf
   // "a", and a branch 8'hFF leading to the very last table entry.
   task automatic test_directed_words();
      send_request(make_write(12'h000, "c", 1'b0, 12'h010, 1'b0));
      send_request(make_write(12'h001, "a", 1'b0, 12'h000, 1'b1));
      send_request(make_write(12'h002, 8'hFF, 1'b1, 12'hFFF, 1'b1));
      send_request(make_write(12'h010, "a", 1'b1, 12'h020, 1'b0));
      send_request(make_write(12'h020, "t", 1'b1, 12'h000, 1'b1));
      send_request(make_write(12'hFFF, 8'h00, 1'b0, 12'hFFF, 1'b1));
      // A full word found, then a prefix that ends on a non-terminal branch.
      send_spelled("cat");
      send_spelled("ca");
      // A one-letter word on a leaf, then a word that runs on past that leaf.
      send_spelled("a");
      send_spelled("ab");
      // A miss at the root, and a failed word that keeps sending letters.
      send_spelled("zzz");
      // The last entry is found; a miss there runs the scan off the table end.
      send_request(make_letter(8'hFF, 1'b0));
      send_request(make_letter(8'h00, 1'b1));
      send_request(make_letter(8'hFF, 1'b0));
      send_request(make_letter(8'h01, 1'b1));
      // A write in the middle of a word changes the branch that the word then takes.
      send_request(make_letter("c", 1'b0));
      send_request(make_write(12'h010, "o", 1'b1, 12'h020, 1'b1));
      send_request(make_letter("o", 1'b1));
   endtask

   // Mostly well-formed words through the current table, some noisy words and
   // stray writes. One stretch in the middle runs back to back with no gaps.
   task automatic test_random_traffic();
      int base;
      int done;
      base = sent_count;
      done = 0;
      while (done < RANDOM_ITEMS) begin
         gaps_on = !(done >= 300 && done < 550);
         if ($urandom_range(9) == 0)
            send_request(random_write());
         else
            send_word($urandom_range(1, 8), $urandom_range(9) == 0);
         done = sent_count - base;
      end
      gaps_on = 1'b1;
   endtask

   // Each strobed result is compared against the oldest outstanding expectation.
   always @(posedge clock) begin
      atwl_pkg::rsp_type want;
      if (!reset && rsp_strobe !== 1'b0) begin
         if (expected_results.size() == 0) begin
            $error("result with none expected: word_found %0b match_index %0h",
                   rsp_item.word_found, rsp_item.match_index);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_item.word_found !== want.word_found) begin
               $error("word_found: expected %0b, got %0b",
                      want.word_found, rsp_item.word_found);
               error_count++;
            end
            if (rsp_item.match_index !== want.match_index) begin
               $error("match_index: expected %0h, got %0h",
                      want.match_index, rsp_item.match_index);
               error_count++;
            end
         end
      end
   end

   initial begin
      reset    = 1'b1;
      start    = 1'b0;
      req_item = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_table_load();
      test_directed_words();
      test_random_traffic();
      start <= 1'b0;
      while (expected_results.size() != 0)
         @(posedge clock);
      // Give a trailing scan time to finish, so a stray result would still be seen.
      repeat (DEPTH + 16) @(posedge clock);
      if (error_count == 0)
         $display("array_trie_word_lookup_tb OK");
      else
         $display("array_trie_word_lookup_tb NOT OK");
      $finish;
   end

   // Hard stop in case the block hangs.
   initial begin
      #20_000_000;
      $display("array_trie_word_lookup_tb NOT OK");
      $finish;
   end

endmodule
